@@ rtl/qcat_pkg.sv @@
// shared types, codes and byte classes for the quote and comment aware tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package qcat_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  // result slots of one input byte, in emission order
  localparam int unsigned NumSlots   = 6;
  localparam int unsigned SLOT_SL_B  = 0;  // held slash byte
  localparam int unsigned SLOT_SL_E  = 1;  // end of held slash token
  localparam int unsigned SLOT_CLOSE = 2;  // end of open token
  localparam int unsigned SLOT_EOL   = 3;  // line end
  localparam int unsigned SLOT_BYTE  = 4;  // the input byte itself
  localparam int unsigned SLOT_BEND  = 5;  // end right after the byte

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [7:0]          ch;
  } bundle_t;

  function automatic logic is_word(input logic [7:0] c);
    is_word = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
              (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

endpackage

`default_nettype wire

@@ rtl/qcat_front.sv @@
// front end: classifies each byte, keeps the mode bits, builds a result bundle
// depends on qcat_pkg
`default_nettype none

module qcat_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        ch_i,
  output qcat_pkg::bundle_t bundle_o,
  output logic              bvalid_o
);
  import qcat_pkg::*;

  logic in_quote_q, in_quote_d;
  logic tok_open_q, tok_open_d;
  logic skip_q, skip_d;
  logic slash_q, slash_d;
  logic [NumSlots-1:0] mask;

  always_comb begin
    mask       = '0;
    in_quote_d = in_quote_q;
    tok_open_d = tok_open_q;
    skip_d     = skip_q;
    slash_d    = 1'b0;
    if (slash_q && ch_i == CH_SLASH) begin
      // double slash, drop the line
      skip_d = 1'b1;
    end else begin
      if (slash_q) begin
        mask[SLOT_SL_B] = 1'b1;
        mask[SLOT_SL_E] = 1'b1;
      end
      priority if (ch_i == CH_NL) begin
        mask[SLOT_CLOSE] = tok_open_q;
        mask[SLOT_EOL]   = 1'b1;
        in_quote_d       = 1'b0;
        skip_d           = 1'b0;
        tok_open_d       = 1'b0;
      end else if (skip_q) begin
        // dropped
      end else if (in_quote_q) begin
        mask[SLOT_BYTE] = 1'b1;
        if (ch_i == CH_QUOTE) begin
          mask[SLOT_BEND] = 1'b1;
          in_quote_d      = 1'b0;
          tok_open_d      = 1'b0;
        end
      end else if (ch_i == CH_QUOTE) begin
        mask[SLOT_CLOSE] = tok_open_q;
        mask[SLOT_BYTE]  = 1'b1;
        tok_open_d       = 1'b1;
        in_quote_d       = 1'b1;
      end else if (ch_i == CH_HASH) begin
        mask[SLOT_CLOSE] = tok_open_q;
        tok_open_d       = 1'b0;
        skip_d           = 1'b1;
      end else if (ch_i == CH_SLASH) begin
        mask[SLOT_CLOSE] = tok_open_q;
        tok_open_d       = 1'b0;
        slash_d          = 1'b1;
      end else if (is_blank(ch_i)) begin
        mask[SLOT_CLOSE] = tok_open_q;
        tok_open_d       = 1'b0;
      end else if (is_word(ch_i)) begin
        mask[SLOT_BYTE] = 1'b1;
        tok_open_d      = 1'b1;
      end else begin
        mask[SLOT_CLOSE] = tok_open_q;
        mask[SLOT_BYTE]  = 1'b1;
        mask[SLOT_BEND]  = 1'b1;
        tok_open_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      tok_open_q <= 1'b0;
      skip_q     <= 1'b0;
      slash_q    <= 1'b0;
    end else if (accept_i) begin
      in_quote_q <= in_quote_d;
      tok_open_q <= tok_open_d;
      skip_q     <= skip_d;
      slash_q    <= slash_d;
    end
  end

  assign bundle_o.mask = mask;
  assign bundle_o.ch   = ch_i;
  assign bvalid_o      = accept_i && (mask != '0);

  // a held slash always follows a closed token outside any string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_q |-> (!tok_open_q && !in_quote_q))
    else $error("slash held with open token or string");

  // a string is always an open token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_quote_q |-> tok_open_q)
    else $error("string mode without open token");

endmodule

`default_nettype wire

@@ rtl/qcat_fifo.sv @@
// short bundle queue between front and back end
// depends on qcat_pkg
`default_nettype none

module qcat_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qcat_pkg::bundle_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output qcat_pkg::bundle_t rdata_o,
  output logic              nempty_o
);
  import qcat_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  bundle_t       mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o   = (cnt_q == Full);
  assign nempty_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // a bundle offered while full would be lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("bundle pushed into full queue");

endmodule

`default_nettype wire

@@ rtl/qcat_back.sv @@
// back end: walks the slots of each bundle and drives the result register
// depends on qcat_pkg
`default_nettype none

module qcat_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qcat_pkg::bundle_t head_i,
  input  logic              head_valid_i,
  output logic              head_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        tok_byte_o,
  output logic              last_o
);
  import qcat_pkg::*;

  logic [NumSlots-1:0] work_mask_q, work_mask_d;
  logic [7:0]          work_ch_q, work_ch_d;
  logic [NumSlots-1:0] sel, rem;
  logic                take, emit, load;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          kind_q, kind_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;

  assign take = !out_valid_q || pop_i;
  assign emit = take && (work_mask_q != '0);
  assign sel  = work_mask_q & (~work_mask_q + NumSlots'(1));
  assign rem  = work_mask_q & ~sel;
  assign load = head_valid_i && ((work_mask_q == '0) || (emit && rem == '0));

  always_comb begin
    work_mask_d = work_mask_q;
    work_ch_d   = work_ch_q;
    if (load) begin
      work_mask_d = head_i.mask;
      work_ch_d   = head_i.ch;
    end else if (emit) begin
      work_mask_d = rem;
    end
  end

  always_comb begin
    kind_d = KIND_END;
    byte_d = 8'h00;
    if (sel[SLOT_SL_B]) begin
      kind_d = KIND_BYTE;
      byte_d = CH_SLASH;
    end else if (sel[SLOT_EOL]) begin
      kind_d = KIND_EOL;
    end else if (sel[SLOT_BYTE]) begin
      kind_d = KIND_BYTE;
      byte_d = work_ch_q;
    end
    last_d      = (rem == '0);
    out_valid_d = emit ? 1'b1 : (take ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_mask_q <= work_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_ch_q <= work_ch_d;
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign head_pop_o = load;
  assign empty_o    = !out_valid_q;
  assign kind_o     = kind_q;
  assign tok_byte_o = byte_q;
  assign last_o     = last_q;

  // a line end and a token byte never come from the same input byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(work_mask_q[SLOT_EOL] && work_mask_q[SLOT_BYTE]))
    else $error("line end and byte in one bundle");

  // a byte result that ends a bundle cannot be a held slash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && sel[SLOT_SL_B] |=> !last_q)
    else $error("held slash marked as final result");

endmodule

`default_nettype wire

@@ rtl/quoted_comment_aware_tokenizer_top.sv @@
// top level of the quote and comment aware tokenizer
// depends on qcat_pkg, qcat_front, qcat_fifo, qcat_back
//
//   channel   direction  handshake                 payload
//   input     in         push / full               ch_i[7:0]
//   result    out        pop / empty               kind_o[1:0], tok_byte_o[7:0], last_o
//
// one text byte can be taken on every clock edge while the bundle queue has room
// each byte gives 0 to 4 results, sent one per cycle from the result register on pop
// a result reaches the ports through the queue entry written at the transfer edge,
// the slot register and then the result register
// a stalled result side fills the queue and raises full; the front keeps its modes
// reset (rst_ni low) clears all modes and the queue and empties the result register
`default_nettype none

module quoted_comment_aware_tokenizer_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] tok_byte_o,
  output logic       last_o
);
  import qcat_pkg::*;

  bundle_t front_bundle, head_bundle;
  logic    front_bvalid, head_valid, head_pop;
  logic    q_full, accept;

  // a byte transfer happens whenever push is high and the queue can take a full bundle
  assign accept = push && !q_full;
  assign full   = q_full;

  qcat_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .bundle_o (front_bundle),
    .bvalid_o (front_bvalid)
  );

  // bytes that give no result leave nothing in the queue
  qcat_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_bvalid),
    .wdata_i  (front_bundle),
    .full_o   (q_full),
    .pop_i    (head_pop),
    .rdata_o  (head_bundle),
    .nempty_o (head_valid)
  );

  // slot walk and result register, one result transfer per cycle while the reader pops
  qcat_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_bundle),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .tok_byte_o   (tok_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
